// File: rtl/wdr_pkg.sv
// ----------------------------------------------------------------------------
// wdr_pkg
// Shared types, constants and the answer tail table for the wildcard DNS
// responder.
// ----------------------------------------------------------------------------
package wdr_pkg;

  localparam int unsigned MaxPacket = 512;
  localparam int unsigned HeaderLen = 12;
  localparam int unsigned AnswerLen = 16;
  localparam int unsigned QTailLen  = 4;   // qtype + qclass
  localparam int unsigned PosW      = $clog2(MaxPacket + 1);
  localparam int unsigned AnsIdxW   = $clog2(AnswerLen);

  typedef logic [PosW-1:0]    wdr_pos_t;
  typedef logic [PosW:0]      wdr_sum_t;
  typedef logic [AnsIdxW-1:0] wdr_ans_idx_t;

  localparam logic [7:0] FlagsHi    = 8'h81;
  localparam logic [7:0] FlagsLo    = 8'h80;
  localparam logic [7:0] NamePtrHi  = 8'hC0;
  localparam logic [7:0] NamePtrLo  = 8'h0C;
  localparam logic [7:0] TtlLo      = 8'h3C;
  localparam logic [7:0] RdLenLo    = 8'h04;
  localparam logic [7:0] OneByte    = 8'h01;
  localparam logic [7:0] ZeroByte   = 8'h00;

  typedef struct packed {
    logic [7:0] query_byte;
    logic       query_end;
  } wdr_query_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_end;
    logic       send_reply;
  } wdr_reply_t;

  // Result of parsing one accepted byte
  typedef struct packed {
    logic       echo;
    logic [7:0] echo_byte;
    logic       last;
    logic       ok;
  } wdr_step_t;

  // Status of the output side
  typedef struct packed {
    logic tail_active;
    logic skid_valid;
  } wdr_stat_t;

  // Byte of the fixed A answer at a given offset
  function automatic logic [7:0] tail_byte(input wdr_ans_idx_t idx,
                                           input logic [31:0] addr);
    logic [7:0] r;
    r = ZeroByte;
    case (idx)
      wdr_ans_idx_t'(0):  r = NamePtrHi;
      wdr_ans_idx_t'(1):  r = NamePtrLo;
      wdr_ans_idx_t'(3):  r = OneByte;    // type A
      wdr_ans_idx_t'(5):  r = OneByte;    // class IN
      wdr_ans_idx_t'(9):  r = TtlLo;
      wdr_ans_idx_t'(11): r = RdLenLo;
      wdr_ans_idx_t'(12): r = addr[31:24];
      wdr_ans_idx_t'(13): r = addr[23:16];
      wdr_ans_idx_t'(14): r = addr[15:8];
      wdr_ans_idx_t'(15): r = addr[7:0];
      default:            r = ZeroByte;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/wdr_parse.sv
// ----------------------------------------------------------------------------
// wdr_parse
// Per-byte query parser: header rewrite, qname label walk and the final
// accept/drop decision.
// ----------------------------------------------------------------------------
module wdr_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  wdr_pkg::wdr_query_t query_i,
  output wdr_pkg::wdr_step_t  step_o
);

  wdr_pkg::wdr_pos_t pos_q, pos_d;
  wdr_pkg::wdr_pos_t next_label_q, next_label_d;
  wdr_pkg::wdr_pos_t qend_q, qend_d;
  logic              done_q, done_d;
  logic              qnz_q, qnz_d;

  wdr_pkg::wdr_sum_t nx;
  wdr_pkg::wdr_sum_t qend_lim;
  logic [7:0]        b;
  logic              ok;

  assign b = query_i.query_byte;

  always_comb begin
    pos_d        = pos_q;
    next_label_d = next_label_q;
    qend_d       = qend_q;
    done_d       = done_q;
    qnz_d        = qnz_q;
    step_o       = '0;
    nx           = wdr_pkg::wdr_sum_t'(pos_q) + wdr_pkg::wdr_sum_t'(b) + 1'b1;

    if (pos_q < wdr_pkg::wdr_pos_t'(wdr_pkg::MaxPacket)) begin
      if (pos_q < wdr_pkg::wdr_pos_t'(wdr_pkg::HeaderLen)) begin
        step_o.echo = 1'b1;
        if (pos_q < wdr_pkg::wdr_pos_t'(2)) begin
          step_o.echo_byte = b;
        end else if (pos_q == wdr_pkg::wdr_pos_t'(2)) begin
          step_o.echo_byte = wdr_pkg::FlagsHi;
        end else if (pos_q == wdr_pkg::wdr_pos_t'(3)) begin
          step_o.echo_byte = wdr_pkg::FlagsLo;
        end else if (pos_q == wdr_pkg::wdr_pos_t'(5) || pos_q == wdr_pkg::wdr_pos_t'(7)) begin
          step_o.echo_byte = wdr_pkg::OneByte;
        end else begin
          step_o.echo_byte = wdr_pkg::ZeroByte;
        end
        if ((pos_q == wdr_pkg::wdr_pos_t'(4) || pos_q == wdr_pkg::wdr_pos_t'(5))
            && b != wdr_pkg::ZeroByte) begin
          qnz_d = 1'b1;
        end
      end else if (!done_q) begin
        step_o.echo      = 1'b1;
        step_o.echo_byte = b;
        if (pos_q == next_label_q) begin
          if (b == wdr_pkg::ZeroByte) begin
            done_d = 1'b1;
            qend_d = pos_q + wdr_pkg::wdr_pos_t'(1 + wdr_pkg::QTailLen);
          end else if (nx > wdr_pkg::wdr_sum_t'(wdr_pkg::MaxPacket)) begin
            // label runs past the limit: park the pointer there
            next_label_d = wdr_pkg::wdr_pos_t'(wdr_pkg::MaxPacket);
          end else begin
            next_label_d = nx[wdr_pkg::PosW-1:0];
          end
        end
      end else if (pos_q < qend_q) begin
        step_o.echo      = 1'b1;
        step_o.echo_byte = b;
      end
      pos_d = pos_q + 1'b1;
    end

    qend_lim = wdr_pkg::wdr_sum_t'(qend_d) + wdr_pkg::wdr_sum_t'(wdr_pkg::AnswerLen);
    ok = (pos_d >= wdr_pkg::wdr_pos_t'(wdr_pkg::HeaderLen)) && qnz_d && done_d
         && (qend_d <= pos_d)
         && (qend_lim <= wdr_pkg::wdr_sum_t'(wdr_pkg::MaxPacket));
    step_o.last = query_i.query_end;
    step_o.ok   = ok;

    // datagram over: start fresh
    if (query_i.query_end) begin
      pos_d        = '0;
      next_label_d = wdr_pkg::wdr_pos_t'(wdr_pkg::HeaderLen);
      qend_d       = '0;
      done_d       = 1'b0;
      qnz_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      next_label_q <= wdr_pkg::wdr_pos_t'(wdr_pkg::HeaderLen);
      qend_q       <= '0;
      done_q       <= 1'b0;
      qnz_q        <= 1'b0;
    end else if (accept_i) begin
      pos_q        <= pos_d;
      next_label_q <= next_label_d;
      qend_q       <= qend_d;
      done_q       <= done_d;
      qnz_q        <= qnz_d;
    end
  end

endmodule

// File: rtl/wdr_out.sv
// ----------------------------------------------------------------------------
// wdr_out
// Output register with skid stage and the answer tail sequencer.
// ----------------------------------------------------------------------------
module wdr_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  wdr_pkg::wdr_step_t  step_i,
  input  logic [31:0]        addr_i,
  output logic               valid_o,
  input  logic               stall_i,
  output wdr_pkg::wdr_reply_t reply_o,
  output wdr_pkg::wdr_stat_t  stat_o
);

  wdr_pkg::wdr_reply_t out_q, out_d, skid_q, skid_d, echo_item;
  logic                outv_q, outv_d, skidv_q, skidv_d;
  logic                tail_q, tail_d, ok_q, ok_d;
  wdr_pkg::wdr_ans_idx_t idx_q, idx_d;
  logic                out_free, idx_last;

  assign out_free = !outv_q || !stall_i;
  assign idx_last = (idx_q == wdr_pkg::wdr_ans_idx_t'(wdr_pkg::AnswerLen - 1));

  always_comb begin
    echo_item            = '0;
    echo_item.reply_byte = step_i.echo_byte;
  end

  always_comb begin
    out_d   = out_q;
    outv_d  = outv_q;
    skid_d  = skid_q;
    skidv_d = skidv_q;
    tail_d  = tail_q;
    ok_d    = ok_q;
    idx_d   = idx_q;

    if (out_free) begin
      outv_d = 1'b0;
    end

    if (skidv_q) begin
      if (out_free) begin
        out_d   = skid_q;
        outv_d  = 1'b1;
        skidv_d = 1'b0;
      end
    end else if (accept_i && step_i.echo) begin
      if (out_free) begin
        out_d  = echo_item;
        outv_d = 1'b1;
      end else begin
        skid_d  = echo_item;
        skidv_d = 1'b1;
      end
    end else if (tail_q && out_free) begin
      outv_d = 1'b1;
      if (ok_q) begin
        out_d.reply_byte = wdr_pkg::tail_byte(idx_q, addr_i);
        out_d.reply_end  = idx_last;
        out_d.send_reply = idx_last;
        idx_d            = idx_q + 1'b1;
        tail_d           = !idx_last;
      end else begin
        // drop item
        out_d.reply_byte = wdr_pkg::ZeroByte;
        out_d.reply_end  = 1'b1;
        out_d.send_reply = 1'b0;
        tail_d           = 1'b0;
      end
    end

    if (accept_i && step_i.last) begin
      tail_d = 1'b1;
      ok_d   = step_i.ok;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outv_q  <= 1'b0;
      skidv_q <= 1'b0;
      tail_q  <= 1'b0;
      ok_q    <= 1'b0;
      idx_q   <= '0;
    end else begin
      outv_q  <= outv_d;
      skidv_q <= skidv_d;
      tail_q  <= tail_d;
      ok_q    <= ok_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign valid_o            = outv_q;
  assign reply_o            = out_q;
  assign stat_o.tail_active = tail_q;
  assign stat_o.skid_valid  = skidv_q;

endmodule

// File: rtl/wildcard_dns_responder.sv
// ----------------------------------------------------------------------------
// wildcard_dns_responder
// Streams a DNS query in and a wildcard A-record reply out, byte by byte.
// ----------------------------------------------------------------------------
// Query bytes are taken one per cycle while the input is not stalled, and each
// header or question byte is echoed through a registered output, or through a
// one-entry skid stage while the consumer stalls, so a stalled consumer costs
// no input bytes until the skid fills. On the final byte the input stalls
// while the output sequencer emits the 16-byte answer or a single drop item.
// The answer address register is written through cfg_we_i and should
// only change between datagrams.
module wildcard_dns_responder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                query_valid_i,
  output logic                query_stall_o,
  input  wdr_pkg::wdr_query_t query_i,
  output logic                reply_valid_o,
  input  logic                reply_stall_i,
  output wdr_pkg::wdr_reply_t reply_o,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i
);

  logic [31:0]        addr_q;
  logic               accept;
  wdr_pkg::wdr_step_t step;
  wdr_pkg::wdr_stat_t stat;

  // hold input while the skid is full or the answer tail is going out
  assign query_stall_o = stat.skid_valid || stat.tail_active;
  assign accept        = query_valid_i && !query_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cfg_we_i) begin
      addr_q <= cfg_wdata_i;
    end
  end

  wdr_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .query_i  (query_i),
    .step_o   (step)
  );

  wdr_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .step_i   (step),
    .addr_i   (addr_q),
    .valid_o  (reply_valid_o),
    .stall_i  (reply_stall_i),
    .reply_o  (reply_o),
    .stat_o   (stat)
  );

  a_drop_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_o && reply_o.reply_end && !reply_o.send_reply
      |-> reply_o.reply_byte == wdr_pkg::ZeroByte)
    else $error("drop item carries a nonzero byte");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && query_i.query_end |=> query_stall_o)
    else $error("input not held after final byte");

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.skid_valid |-> reply_valid_o)
    else $error("skid holds an item with the output register empty");

  a_send_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_o && reply_o.send_reply |-> reply_o.reply_end)
    else $error("send flag on a non-final item");

endmodule
